>>> rtl/core/life_generation_stencil_core_defines.svh
// Assertion macros for the life generation stencil core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LIFE_GENERATION_STENCIL_CORE_DEFINES_SVH
`define LIFE_GENERATION_STENCIL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lgs_pkg.sv
// Shared types, constants and the B3/S23 cell rule for the life stencil core.
// No dependencies.
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned ROWS_REG_W  = 11;
  localparam int unsigned COLS_REG_W  = 6;
  localparam int unsigned ROW_OUT_W   = 10;
  localparam int unsigned COL_OUT_W   = 5;
  localparam int unsigned ROW_CAP_W   = 16;
  localparam int unsigned COL_CAP_W   = 6;

  localparam int unsigned DEF_MAX_COLS = 32;
  localparam int unsigned DEF_MAX_ROWS = 1024;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [ROWS_REG_W-1:0] RESET_GRID_ROWS = 11'd30;
  localparam logic [COLS_REG_W-1:0] RESET_GRID_COLS = 6'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_ROWS = 2'd0,
    CFG_GRID_COLS = 2'd1
  } lgs_cfg_idx_e;

  // One unit of work for the back end: up to two interior cells, then
  // optionally the whole last row of the frame.
  typedef struct packed {
    logic [1:0]           n_cells;
    logic                 alive0;
    logic                 alive1;
    logic                 flush;
    logic [ROW_CAP_W-1:0] row;       // input row; interior cells sit one above
    logic [COL_CAP_W-1:0] col0;      // column of the first interior cell
    logic [COL_CAP_W-1:0] last_col;  // last column in use
  } lgs_job_t;

  // Windows hold bits left, center, right at [0], [1], [2].
  function automatic logic life_next(logic [2:0] above, logic [2:0] mid,
                                     logic [2:0] below);
    logic [3:0] n;
    n = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
      + 4'(below[0]) + 4'(below[1]) + 4'(below[2])
      + 4'(mid[0]) + 4'(mid[2]);
    return (n == 4'd3) || ((n == 4'd2) && mid[1]);
  endfunction

endpackage

>>> rtl/core/lgs_if.sv
// Handshake channels of the life stencil core: cell input, result output
// and configuration write. Depends on lgs_pkg.
`timescale 1ns / 1ps

interface lgs_cell_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink   (input valid, input cell_alive, output ready);
endinterface

interface lgs_result_if;
  logic                          valid;
  logic                          ready;
  logic                          next_alive;
  logic [lgs_pkg::ROW_OUT_W-1:0] out_row;
  logic [lgs_pkg::COL_OUT_W-1:0] out_col;
  logic                          frame_done;
  logic                          run_last;

  modport source (output valid, output next_alive, output out_row, output out_col,
                  output frame_done, output run_last, input ready);
  modport sink   (input valid, input next_alive, input out_row, input out_col,
                  input frame_done, input run_last, output ready);
endinterface

interface lgs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lgs_pkg::CFG_IDX_W-1:0]  index;
  logic [lgs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/lgs_front.sv
// Front end: configuration registers, row stores and positions. Accepts
// cells, evaluates interior cells and queues jobs. Depends on lgs_pkg, lgs_if.
`timescale 1ns / 1ps

module lgs_front #(
  parameter int unsigned MAX_COLS = lgs_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lgs_cfg_if.sink           cfg_i,
  lgs_cell_if.sink          cell_i,
  input  logic              full_i,
  output logic              push_o,
  output lgs_pkg::lgs_job_t job_o,
  output logic [MAX_COLS-1:0] mid_o,
  output logic [MAX_COLS-1:0] cur_o
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned EW = (RW + 1 > lgs_pkg::ROWS_REG_W) ? RW + 1 : lgs_pkg::ROWS_REG_W;
  localparam int unsigned PW = MAX_COLS + 2;

  logic [lgs_pkg::ROWS_REG_W-1:0] grid_rows_q, grid_rows_d;
  logic [lgs_pkg::COLS_REG_W-1:0] grid_cols_q, grid_cols_d;
  logic [MAX_COLS-1:0] upper_q, upper_d, middle_q, middle_d, current_q, current_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;

  logic [lgs_pkg::COLS_REG_W-1:0] cols_eff, cols_last;
  logic [EW-1:0] rows_ext, rows_eff, rows_last;
  logic row_end, last_row, accept, cfg_hit;
  logic [MAX_COLS-1:0] cur_new;
  logic [PW-1:0] up_p, mid_p, cur_p;
  logic [CW-1:0] j0;
  logic [1:0] n_cells;
  logic a0, a1;

  always_comb begin
    if (grid_cols_q < 6'd2) begin
      cols_eff = 6'd2;
    end else if (grid_cols_q > 6'(MAX_COLS)) begin
      cols_eff = 6'(MAX_COLS);
    end else begin
      cols_eff = grid_cols_q;
    end
    rows_ext = EW'(grid_rows_q);
    if (rows_ext < EW'(2)) begin
      rows_eff = EW'(2);
    end else if (rows_ext > EW'(MAX_ROWS)) begin
      rows_eff = EW'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
  end

  assign cols_last = cols_eff - 6'd1;
  assign rows_last = rows_eff - EW'(1);
  assign row_end   = 6'(col_q) >= cols_last;
  assign last_row  = EW'(row_q) >= rows_last;

  assign cfg_i.ready  = 1'b1;
  assign cell_i.ready = !full_i;
  assign accept       = cell_i.valid && cell_i.ready;

  assign cur_new = current_q | (MAX_COLS'(cell_i.cell_alive) << col_q);
  assign up_p    = {1'b0, upper_q, 1'b0};
  assign mid_p   = {1'b0, middle_q, 1'b0};
  assign cur_p   = {1'b0, cur_new, 1'b0};
  assign j0      = (col_q == '0) ? '0 : col_q - CW'(1);

  assign a0 = lgs_pkg::life_next(up_p[j0 +: 3], mid_p[j0 +: 3], cur_p[j0 +: 3]);
  assign a1 = lgs_pkg::life_next(up_p[col_q +: 3], mid_p[col_q +: 3], cur_p[col_q +: 3]);

  always_comb begin
    n_cells = 2'd0;
    if (row_q != '0 && col_q != '0) begin
      n_cells = row_end ? 2'd2 : 2'd1;
    end
  end

  always_comb begin
    job_o          = '0;
    job_o.n_cells  = n_cells;
    job_o.alive0   = a0;
    job_o.alive1   = a1;
    job_o.flush    = row_end && last_row;
    job_o.row      = lgs_pkg::ROW_CAP_W'(row_q);
    job_o.col0     = lgs_pkg::COL_CAP_W'(j0);
    job_o.last_col = cols_last;
  end

  assign mid_o  = middle_q;
  assign cur_o  = cur_new;
  assign push_o = accept && ((n_cells != 2'd0) || (row_end && last_row));

  always_comb begin
    grid_rows_d = grid_rows_q;
    grid_cols_d = grid_cols_q;
    upper_d     = upper_q;
    middle_d    = middle_q;
    current_d   = current_q;
    row_d       = row_q;
    col_d       = col_q;
    cfg_hit     = 1'b0;
    if (cfg_i.valid && cfg_i.ready) begin
      case (lgs_pkg::lgs_cfg_idx_e'(cfg_i.index))
        lgs_pkg::CFG_GRID_ROWS: begin
          grid_rows_d = cfg_i.data;
          cfg_hit     = 1'b1;
        end
        lgs_pkg::CFG_GRID_COLS: begin
          grid_cols_d = cfg_i.data[lgs_pkg::COLS_REG_W-1:0];
          cfg_hit     = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    if (cfg_hit) begin
      // abandon the frame in progress
      upper_d   = '0;
      middle_d  = '0;
      current_d = '0;
      row_d     = '0;
      col_d     = '0;
    end else if (accept) begin
      if (row_end) begin
        if (last_row) begin
          upper_d   = '0;
          middle_d  = '0;
          current_d = '0;
          row_d     = '0;
        end else begin
          upper_d   = middle_q;
          middle_d  = cur_new;
          current_d = '0;
          row_d     = row_q + RW'(1);
        end
        col_d = '0;
      end else begin
        current_d = cur_new;
        col_d     = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= lgs_pkg::RESET_GRID_ROWS;
      grid_cols_q <= lgs_pkg::RESET_GRID_COLS;
      upper_q     <= '0;
      middle_q    <= '0;
      current_q   <= '0;
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      grid_rows_q <= grid_rows_d;
      grid_cols_q <= grid_cols_d;
      upper_q     <= upper_d;
      middle_q    <= middle_d;
      current_q   <= current_d;
      row_q       <= row_d;
      col_q       <= col_d;
    end
  end

endmodule

>>> rtl/core/lgs_queue.sv
// Small first-in first-out queue of jobs between front and back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module lgs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = cnt_q == NW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

>>> rtl/core/lgs_back.sv
// Back end: steps through each queued job, one result per cycle while out_o is
// ready, holding each result in an output register. Depends on lgs_pkg, lgs_if.
`timescale 1ns / 1ps

module lgs_back #(
  parameter int unsigned MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  lgs_pkg::lgs_job_t   job_i,
  input  logic [MAX_COLS-1:0] mid_i,
  input  logic [MAX_COLS-1:0] cur_i,
  output logic                pop_o,
  lgs_result_if.source        out_o
);

  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned SW = $clog2(MAX_COLS + 3);
  localparam int unsigned PW = MAX_COLS + 2;

  logic [SW-1:0] step_q, step_d, total, step_flush;
  logic [CW-1:0] jdx;
  logic [PW-1:0] mid_p, cur_p;
  logic load, last_step, in_cells;

  logic                          valid_q, valid_d;
  logic                          alive_q, alive_d;
  logic [lgs_pkg::ROW_OUT_W-1:0] row_q, row_d;
  logic [lgs_pkg::COL_OUT_W-1:0] col_q, col_d;
  logic                          done_q, done_d;
  logic                          last_q, last_d;

  assign total = SW'(job_i.n_cells)
               + (job_i.flush ? SW'(job_i.last_col) + SW'(1) : '0);
  assign last_step  = step_q == total - SW'(1);
  assign in_cells   = step_q < SW'(job_i.n_cells);
  assign step_flush = step_q - SW'(job_i.n_cells);
  assign jdx        = CW'(step_flush);
  assign mid_p      = {1'b0, mid_i, 1'b0};
  assign cur_p      = {1'b0, cur_i, 1'b0};

  assign load  = !empty_i && (!valid_q || out_o.ready);
  assign pop_o = load && last_step;

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    alive_d = alive_q;
    row_d   = row_q;
    col_d   = col_q;
    done_d  = done_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      step_d  = last_step ? '0 : step_q + SW'(1);
      last_d  = last_step;
      if (in_cells) begin
        alive_d = (step_q == '0) ? job_i.alive0 : job_i.alive1;
        row_d   = lgs_pkg::ROW_OUT_W'(job_i.row - lgs_pkg::ROW_CAP_W'(1));
        col_d   = lgs_pkg::COL_OUT_W'(job_i.col0 + lgs_pkg::COL_CAP_W'(step_q));
        done_d  = 1'b0;
      end else begin
        // drain the last row; nothing lies below it
        alive_d = lgs_pkg::life_next(mid_p[jdx +: 3], cur_p[jdx +: 3], 3'b000);
        row_d   = lgs_pkg::ROW_OUT_W'(job_i.row);
        col_d   = lgs_pkg::COL_OUT_W'(jdx);
        done_d  = lgs_pkg::COL_CAP_W'(jdx) == job_i.last_col;
      end
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alive_q <= alive_d;
    row_q   <= row_d;
    col_q   <= col_d;
    done_q  <= done_d;
    last_q  <= last_d;
  end

  assign out_o.valid      = valid_q;
  assign out_o.next_alive = alive_q;
  assign out_o.out_row    = row_q;
  assign out_o.out_col    = col_q;
  assign out_o.frame_done = done_q;
  assign out_o.run_last   = last_q;

endmodule

>>> rtl/core/life_generation_stencil_core.sv
// Top level of the Game of Life (B3/S23) streaming stencil core.
// Depends on lgs_pkg, lgs_if, lgs_front, lgs_queue, lgs_back and the defines header.
`timescale 1ns / 1ps
`include "life_generation_stencil_core_defines.svh"

// Streams one generation of a bounded grid in row-major order, one cell per
// item, and returns the next generation with row and column of each cell.
// Results lag their input by one row and one column; cells beyond the edge
// are dead. The input takes an item every cycle while the four-entry job queue
// has room. The back end emits one result per cycle while the output takes them,
// which matches the input rate over a row (grid_cols results per row). At the
// last item of a frame the back end drains the final row, at most grid_cols + 2
// results; the first row of the next frame produces no results, so the queue
// absorbs the drain and the input stalls only while the output is held off. Each
// result passes from the job queue into the back end's output register. Writing
// grid_rows or grid_cols restarts the frame at row 0, column 0; write only while
// the core is idle.
module life_generation_stencil_core #(
  parameter int unsigned MAX_COLS = lgs_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lgs_cfg_if.sink      cfg_i,
  lgs_cell_if.sink     in_i,
  lgs_result_if.source out_o
);

  localparam int unsigned JOB_W = $bits(lgs_pkg::lgs_job_t);
  localparam int unsigned QW    = JOB_W + 2 * MAX_COLS;

  logic              q_push, q_pop, q_full, q_empty;
  lgs_pkg::lgs_job_t job_in, job_out;
  logic [MAX_COLS-1:0] mid_in, cur_in, mid_out, cur_out;
  logic [QW-1:0]     q_din, q_dout;

  lgs_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cell_i(in_i),
    .full_i(q_full),
    .push_o(q_push),
    .job_o (job_in),
    .mid_o (mid_in),
    .cur_o (cur_in)
  );

  assign q_din = {job_in, mid_in, cur_in};

  lgs_queue #(
    .WIDTH(QW),
    .DEPTH(lgs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .din_i  (q_din),
    .pop_i  (q_pop),
    .dout_o (q_dout),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  assign job_out = lgs_pkg::lgs_job_t'(q_dout[QW-1 -: JOB_W]);
  assign mid_out = q_dout[2*MAX_COLS-1 -: MAX_COLS];
  assign cur_out = q_dout[MAX_COLS-1:0];

  lgs_back #(
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(q_empty),
    .job_i  (job_out),
    .mid_i  (mid_out),
    .cur_i  (cur_out),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

  `LGS_ASSERT_NOW(a_push_not_full, clk_i, rst_ni, q_push, !q_full, "job pushed into full queue")
  `LGS_ASSERT_NOW(a_pop_not_empty, clk_i, rst_ni, q_pop, !q_empty, "job popped from empty queue")
  `LGS_ASSERT_NOW(a_done_is_last, clk_i, rst_ni, out_o.valid && out_o.frame_done, out_o.run_last, "frame end not last of run")
  `LGS_ASSERT_NEXT(a_full_holds, clk_i, rst_ni, q_full && !q_pop, q_full, "full queue drained without pop")

endmodule

>>> dv/tb_life_generation_stencil_core.sv
// Self-checking bench for life_generation_stencil_core: streams cell frames,
// predicts each next-generation cell by the B3/S23 rule and compares results.
// Depends on lgs_pkg, lgs_if and the core RTL.
`timescale 1ns / 1ps

module tb_life_generation_stencil_core;

  localparam logic [lgs_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic                          alive;
    logic [lgs_pkg::ROW_OUT_W-1:0] row;
    logic [lgs_pkg::COL_OUT_W-1:0] col;
    logic                          done;
    logic                          last;
  } cell_result_t;

  logic clk_i;
  logic rst_ni;

  lgs_cell_if   cell_if ();
  lgs_result_if res_if ();
  lgs_cfg_if    cfg_if ();

  life_generation_stencil_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (cell_if),
    .out_o  (res_if)
  );

  // Predictor state: sizes as written and the three row stores.
  logic [lgs_pkg::ROWS_REG_W-1:0] rows_cfg;
  logic [lgs_pkg::COLS_REG_W-1:0] cols_cfg;
  logic [31:0]           row_above;
  logic [31:0]           row_mid;
  logic [31:0]           row_fill;
  int                    cur_row;
  int                    cur_col;

  bit           cell_queue [$];
  cell_result_t next_gen_q [$];

  int err_count;
  int idle_cycles;
  bit idle_on;
  bit cell_taken;
  int gap_left;
  int stall_left;
  int hold_left;
  int hold_asked;
  int hold_served;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int neighbor(logic [31:0] row, int idx);
    if (idx < 0 || idx > 31) return 0;
    return int'(row[idx]);
  endfunction

  function automatic bit b3s23_fate(logic [31:0] above, logic [31:0] here,
                                    logic [31:0] below, int col);
    int n;
    n = neighbor(here, col - 1) + neighbor(here, col + 1);
    for (int d = -1; d <= 1; d++) begin
      n += neighbor(above, col + d) + neighbor(below, col + d);
    end
    return (n == 3) || (n == 2 && neighbor(here, col) == 1);
  endfunction

  function automatic void clear_grid();
    row_above = '0;
    row_mid   = '0;
    row_fill  = '0;
    cur_row   = 0;
    cur_col   = 0;
  endfunction

  function automatic cell_result_t make_result(bit alive, int row, int col);
    cell_result_t res;
    res.alive = alive;
    res.row   = row[lgs_pkg::ROW_OUT_W-1:0];
    res.col   = col[lgs_pkg::COL_OUT_W-1:0];
    res.done  = 1'b0;
    res.last  = 1'b0;
    return res;
  endfunction

  // Take one cell and queue every next-generation cell it completes.
  function automatic void predict_next_cells(bit alive);
    cell_result_t batch [0:35];
    int k;
    int rows;
    int cols;
    bit row_end;
    k    = 0;
    rows = (rows_cfg < 2) ? 2 :
           (rows_cfg > lgs_pkg::DEF_MAX_ROWS) ? int'(lgs_pkg::DEF_MAX_ROWS) : int'(rows_cfg);
    cols = (cols_cfg < 2) ? 2 :
           (cols_cfg > lgs_pkg::DEF_MAX_COLS) ? int'(lgs_pkg::DEF_MAX_COLS) : int'(cols_cfg);
    row_end = (cur_col >= cols - 1);
    if (alive) row_fill[cur_col] = 1'b1;
    if (cur_row >= 1) begin
      if (cur_col >= 1) begin
        batch[k] = make_result(b3s23_fate(row_above, row_mid, row_fill, cur_col - 1),
                               cur_row - 1, cur_col - 1);
        k++;
      end
      if (row_end) begin
        batch[k] = make_result(b3s23_fate(row_above, row_mid, row_fill, cur_col),
                               cur_row - 1, cur_col);
        k++;
      end
    end
    if (row_end) begin
      if (cur_row >= rows - 1) begin
        // Last cell of the frame: flush the final row, below it is all dead.
        for (int j = 0; j < cols; j++) begin
          batch[k] = make_result(b3s23_fate(row_mid, row_fill, '0, j), cur_row, j);
          k++;
        end
        batch[k-1].done = 1'b1;
        clear_grid();
      end else begin
        row_above = row_mid;
        row_mid   = row_fill;
        row_fill  = '0;
        cur_row++;
        cur_col   = 0;
      end
    end else begin
      cur_col++;
    end
    if (k > 0) batch[k-1].last = 1'b1;
    for (int i = 0; i < k; i++) next_gen_q.push_back(batch[i]);
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Monitor: config writes, cell intake and result checking, all at the rising edge.
  always @(posedge clk_i) begin
    bit cfg_fire;
    bit res_fire;
    cell_result_t exp_res;
    cfg_fire   = 1'b0;
    res_fire   = 1'b0;
    cell_taken = 1'b0;
    if (rst_ni) begin
      cfg_fire   = cfg_if.valid && cfg_if.ready;
      cell_taken = cell_if.valid && cell_if.ready;
      res_fire   = res_if.valid && res_if.ready;
      if (cfg_fire) begin
        case (cfg_if.index)
          lgs_pkg::CFG_GRID_ROWS: begin
            rows_cfg = cfg_if.data;
            clear_grid();
          end
          lgs_pkg::CFG_GRID_COLS: begin
            cols_cfg = cfg_if.data[lgs_pkg::COLS_REG_W-1:0];
            clear_grid();
          end
          default: ;
        endcase
      end
      if (cell_taken) predict_next_cells(cell_if.cell_alive);
      if (res_fire) begin
        if (next_gen_q.size() == 0) begin
          flag_error($sformatf("unexpected result at row %0d col %0d",
                               res_if.out_row, res_if.out_col));
        end else begin
          exp_res = next_gen_q.pop_front();
          if (res_if.next_alive !== exp_res.alive)
            flag_error($sformatf("next_alive %0b, want %0b at row %0d col %0d",
                                 res_if.next_alive, exp_res.alive, exp_res.row, exp_res.col));
          if (res_if.out_row !== exp_res.row)
            flag_error($sformatf("out_row %0d, want %0d", res_if.out_row, exp_res.row));
          if (res_if.out_col !== exp_res.col)
            flag_error($sformatf("out_col %0d, want %0d", res_if.out_col, exp_res.col));
          if (res_if.frame_done !== exp_res.done)
            flag_error($sformatf("frame_done %0b, want %0b at row %0d col %0d",
                                 res_if.frame_done, exp_res.done, exp_res.row, exp_res.col));
          if (res_if.run_last !== exp_res.last)
            flag_error($sformatf("run_last %0b, want %0b at row %0d col %0d",
                                 res_if.run_last, exp_res.last, exp_res.row, exp_res.col));
        end
      end
      if (cfg_fire || cell_taken || res_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Cell driver: hold an offered item until taken, then advance or idle.
  always @(negedge clk_i) begin
    bit v;
    bit d;
    v = cell_if.valid;
    d = cell_if.cell_alive;
    if (!rst_ni) begin
      v = 1'b0;
    end else if (!v || cell_taken) begin
      v = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(1, 15) - 1;
      end else if (cell_queue.size() > 0) begin
        v = 1'b1;
        d = cell_queue.pop_front();
      end
    end
    cell_if.valid      <= v;
    cell_if.cell_alive <= d;
  end

  // Result receiver: random stalls plus an occasional long hold-off.
  always @(negedge clk_i) begin
    bit rdy;
    rdy = 1'b1;
    if (hold_served != hold_asked) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      rdy = 1'b0;
    end
    res_if.ready <= rdy;
  end

  task automatic write_reg(logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                           logic [lgs_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every queued cell is taken and every result has come back.
  task automatic settle();
    do @(posedge clk_i);
    while (cell_queue.size() != 0 || cell_if.valid || next_gen_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_pattern(logic [31:0] bits, int first, int count);
    for (int i = first; i < first + count; i++) cell_queue.push_back(bits[i]);
  endtask

  // Random cells; density varies so both sparse and crowded frames occur.
  task automatic queue_cells(int n);
    int density;
    case ($urandom_range(0, 3))
      0:       density = 5;
      1:       density = 30;
      2:       density = 50;
      default: density = 80;
    endcase
    for (int i = 0; i < n; i++) cell_queue.push_back($urandom_range(0, 99) < density);
  endtask

  task automatic run_grid(logic [lgs_pkg::CFG_DATA_W-1:0] rows_val,
                          logic [lgs_pkg::CFG_DATA_W-1:0] cols_val,
                          int frame_len, int frames);
    settle();
    write_reg(lgs_pkg::CFG_GRID_COLS, cols_val);
    write_reg(lgs_pkg::CFG_GRID_ROWS, rows_val);
    for (int f = 0; f < frames; f++) queue_cells(frame_len);
  endtask

  initial begin
    rst_ni             = 1'b0;
    cell_if.valid      = 1'b0;
    cell_if.cell_alive = 1'b0;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = lgs_pkg::CFG_GRID_ROWS;
    cfg_if.data        = '0;
    rows_cfg           = lgs_pkg::RESET_GRID_ROWS;
    cols_cfg           = lgs_pkg::RESET_GRID_COLS;
    clear_grid();
    err_count   = 0;
    idle_cycles = 0;
    idle_on     = 1'b1;
    cell_taken  = 1'b0;
    gap_left    = 0;
    stall_left  = 0;
    hold_left   = 0;
    hold_asked  = 0;
    hold_served = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Power-up sizes: a partial frame, then abandon it with the next write.
    queue_cells(35);

    // Clamp of tiny sizes to 2x2: still block, lone cell, birth, empty.
    settle();
    write_reg(lgs_pkg::CFG_GRID_ROWS, '0);
    write_reg(lgs_pkg::CFG_GRID_COLS, 11'd1);
    queue_pattern(32'hF, 0, 4);
    queue_pattern(32'h1, 0, 4);
    queue_pattern(32'h7, 0, 4);
    queue_pattern(32'h0, 0, 4);

    // Blinker on 3x3; a write to an unused index mid-frame must be ignored.
    settle();
    write_reg(lgs_pkg::CFG_GRID_ROWS, 11'd3);
    write_reg(lgs_pkg::CFG_GRID_COLS, 11'd3);
    queue_pattern(32'h38, 0, 4);
    settle();
    write_reg(CFG_IDX_SPARE, 11'h7FF);
    queue_pattern(32'h38, 4, 5);

    // Largest sizes through clamping; abandoned after three rows.
    run_grid(11'h7FF, 11'd63, 96, 1);
    // Full-width frame while the receiver holds off for a long stretch.
    settle();
    hold_asked++;
    run_grid(11'd5, 11'd32, 160, 1);
    run_grid(11'd4, 11'd5, 20, 2);
    run_grid(11'd1, 11'd7, 14, 2);
    run_grid(11'd2, 11'd33, 64, 1);

    // Final stretch at full rate on both sides.
    settle();
    idle_on = 1'b0;
    run_grid(11'd3, 11'd2, 6, 4);
    run_grid(11'd6, 11'd3, 18, 1);

    settle();
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> life_generation_stencil_core.f
+incdir+rtl/core
rtl/core/lgs_pkg.sv
rtl/core/lgs_if.sv
rtl/core/lgs_front.sv
rtl/core/lgs_queue.sv
rtl/core/lgs_back.sv
rtl/core/life_generation_stencil_core.sv
dv/tb_life_generation_stencil_core.sv
